// File: design/pwm_channel_mark_space_and_distributed_macros.svh
// ----------------------------------------------------------------------------
// pwm_channel_mark_space_and_distributed_macros
// Assertion macros for the PWM channel block. Each macro takes a label,
// clock, active-low reset, antecedent and consequent.
// ----------------------------------------------------------------------------
`ifndef PWM_CHANNEL_MARK_SPACE_AND_DISTRIBUTED_MACROS_SVH
`define PWM_CHANNEL_MARK_SPACE_AND_DISTRIBUTED_MACROS_SVH

// Same-cycle implication
`define PWMMS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pwm channel check failed");

// Next-cycle implication
`define PWMMS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pwm channel check failed");

`endif

// File: design/pwmms_pkg.sv
// ----------------------------------------------------------------------------
// pwmms_pkg
// Shared constants and types for the PWM channel: defaults, register
// indexes and the result record.
// ----------------------------------------------------------------------------
package pwmms_pkg;

    localparam int DEF_COUNT_WIDTH   = 32;
    localparam int DEF_DIVISOR_WIDTH = 12;
    localparam int CFG_INDEX_WIDTH   = 3;
    localparam int CFG_DATA_WIDTH    = 32;
    localparam int RANGE_RESET       = 32;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_CLOCK_DIVISOR   = 3'd0,
        REG_CLOCK_ENABLE    = 3'd1,
        REG_RANGE_COUNT     = 3'd2,
        REG_DUTY_COUNT      = 3'd3,
        REG_CHANNEL_ENABLE  = 3'd4,
        REG_MARK_SPACE_MODE = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic pwm_level;
        logic period_wrap;
    } result_t;

endpackage

// File: design/pwmms_outbuf.sv
// ----------------------------------------------------------------------------
// pwmms_outbuf
// Two-slot output buffer: an output register plus a skid slot, so the
// input takes one transaction per cycle while one result waits; two stall it.
// ----------------------------------------------------------------------------
module pwmms_outbuf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  pwmms_pkg::result_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output pwmms_pkg::result_t out_data
);

    logic               out_valid_reg;
    logic               skid_valid_reg;
    pwmms_pkg::result_t out_data_reg;
    pwmms_pkg::result_t skid_data_reg;
    logic               in_take;
    logic               load_out;
    logic               load_skid;
    logic               drain;

    assign in_ready  = !skid_valid_reg;
    assign in_take   = in_valid && in_ready;
    assign load_out  = in_take && (!out_valid_reg || out_ready);
    assign load_skid = in_take && out_valid_reg && !out_ready;
    assign drain     = !in_take && out_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (load_skid) begin
                skid_valid_reg <= 1'b1;
            end else if (drain) begin
                // advance the skid slot into the output register
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= in_data;
        end else if (load_skid) begin
            skid_data_reg <= in_data;
        end else if (drain) begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: design/pwm_channel_mark_space_and_distributed.sv
// ----------------------------------------------------------------------------
// pwm_channel_mark_space_and_distributed
// PWM output channel with integer clock divider, mark-space and
// distributed (sigma-delta style) modes. One transaction = one source cycle.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  --------+--------------------------------+-------------------------------
//  cfg     | cfg_valid / cfg_ready          | cfg_index, cfg_wdata
//  input   | s_valid / s_ready              | s_advance
//  result  | m_valid / m_ready              | m_pwm_level, m_period_wrap
//
//  One transaction per cycle while s_ready is high; each result is
//  registered in the output buffer as its input is taken. The counter
//  update is combinational logic on registered state, so back-to-back
//  inputs chain through the state registers. s_ready drops only when both
//  output slots (output + skid) are full. Reset (aresetn low, synchronous)
//  loads register defaults and clears all counters; cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "pwm_channel_mark_space_and_distributed_macros.svh"

module pwm_channel_mark_space_and_distributed #(
    parameter int COUNT_WIDTH   = pwmms_pkg::DEF_COUNT_WIDTH,
    parameter int DIVISOR_WIDTH = pwmms_pkg::DEF_DIVISOR_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pwmms_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [pwmms_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_advance,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_pwm_level,
    output logic                                 m_period_wrap
);

    // configuration registers and values derived at write time
    logic [DIVISOR_WIDTH-1:0] clock_divisor_reg, clock_divisor_next;
    logic                     clock_enable_reg, clock_enable_next;
    logic [COUNT_WIDTH-1:0]   range_reg, range_next;
    logic [COUNT_WIDTH-1:0]   duty_reg, duty_next;
    logic                     chan_en_reg, chan_en_next;
    logic                     mark_space_reg, mark_space_next;
    logic [COUNT_WIDTH-1:0]   range_last_reg, range_last_next;
    logic                     range_zero_reg, range_zero_next;
    logic [COUNT_WIDTH-1:0]   duty_eff_reg, duty_eff_next;
    logic [COUNT_WIDTH-1:0]   gap_reg, gap_next;

    // channel state
    logic [DIVISOR_WIDTH-1:0] div_cnt_reg, div_cnt_next;
    logic [COUNT_WIDTH-1:0]   pos_reg, pos_next;
    logic [COUNT_WIDTH-1:0]   acc_reg, acc_next;
    logic                     level_reg, level_next;
    logic                     wrap;

    logic                     cfg_write;
    logic [COUNT_WIDTH-1:0]   wr_count;
    logic [DIVISOR_WIDTH-1:0] wr_div;
    logic                     s_take;
    logic                     div_small;
    logic [DIVISOR_WIDTH-1:0] div_eff;
    logic [DIVISOR_WIDTH-1:0] div_inc;
    logic                     tick;
    logic                     pulse;
    logic                     acc_over;
    logic [COUNT_WIDTH-1:0]   acc_eff;
    logic                     acc_hit;
    logic                     pos_last;
    pwmms_pkg::result_t       result;
    pwmms_pkg::result_t       m_data;
    logic                     disabled_take;
    logic                     state_clear;
    logic                     wrap_take;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign wr_count  = cfg_wdata[COUNT_WIDTH-1:0];
    assign wr_div    = cfg_wdata[DIVISOR_WIDTH-1:0];

    always_comb begin
        clock_divisor_next = clock_divisor_reg;
        clock_enable_next  = clock_enable_reg;
        range_next         = range_reg;
        duty_next          = duty_reg;
        chan_en_next       = chan_en_reg;
        mark_space_next    = mark_space_reg;
        range_last_next    = range_last_reg;
        range_zero_next    = range_zero_reg;
        duty_eff_next      = duty_eff_reg;
        gap_next           = gap_reg;
        if (cfg_write) begin
            unique case (pwmms_pkg::cfg_index_t'(cfg_index))
                pwmms_pkg::REG_CLOCK_DIVISOR:   clock_divisor_next = wr_div;
                pwmms_pkg::REG_CLOCK_ENABLE:    clock_enable_next  = cfg_wdata[0];
                pwmms_pkg::REG_RANGE_COUNT: begin
                    range_next      = wr_count;
                    range_last_next = wr_count - COUNT_WIDTH'(1);
                    range_zero_next = (wr_count == '0);
                    // clamp the stored duty against the new range
                    duty_eff_next   = (duty_reg > wr_count) ? wr_count : duty_reg;
                    gap_next        = (duty_reg > wr_count) ? '0 : wr_count - duty_reg;
                end
                pwmms_pkg::REG_DUTY_COUNT: begin
                    duty_next     = wr_count;
                    duty_eff_next = (wr_count > range_reg) ? range_reg : wr_count;
                    gap_next      = (wr_count > range_reg) ? '0 : range_reg - wr_count;
                end
                pwmms_pkg::REG_CHANNEL_ENABLE:  chan_en_next    = cfg_wdata[0];
                pwmms_pkg::REG_MARK_SPACE_MODE: mark_space_next = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_divisor_reg <= '0;
            clock_enable_reg  <= 1'b0;
            range_reg         <= COUNT_WIDTH'(pwmms_pkg::RANGE_RESET);
            duty_reg          <= '0;
            chan_en_reg       <= 1'b0;
            mark_space_reg    <= 1'b0;
            range_last_reg    <= COUNT_WIDTH'(pwmms_pkg::RANGE_RESET - 1);
            range_zero_reg    <= 1'b0;
            duty_eff_reg      <= '0;
            gap_reg           <= COUNT_WIDTH'(pwmms_pkg::RANGE_RESET);
        end else begin
            clock_divisor_reg <= clock_divisor_next;
            clock_enable_reg  <= clock_enable_next;
            range_reg         <= range_next;
            duty_reg          <= duty_next;
            chan_en_reg       <= chan_en_next;
            mark_space_reg    <= mark_space_next;
            range_last_reg    <= range_last_next;
            range_zero_reg    <= range_zero_next;
            duty_eff_reg      <= duty_eff_next;
            gap_reg           <= gap_next;
        end
    end

    // clock divider: divisors below two act as two
    assign div_small = (clock_divisor_reg < DIVISOR_WIDTH'(2));
    assign div_eff   = div_small ? DIVISOR_WIDTH'(2) : clock_divisor_reg;
    assign div_inc   = div_cnt_reg + DIVISOR_WIDTH'(1);
    assign tick      = (div_inc >= div_eff);
    assign pulse     = s_advance && clock_enable_reg && tick;

    // distributed mode: acc + duty >= range  <=>  acc >= range - duty
    assign acc_over = (acc_reg >= range_reg);
    assign acc_eff  = acc_over ? '0 : acc_reg;
    assign acc_hit  = (acc_eff >= gap_reg);
    assign pos_last = (pos_reg >= range_last_reg);

    always_comb begin
        div_cnt_next = div_cnt_reg;
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        level_next   = level_reg;
        wrap         = 1'b0;
        if (s_advance && clock_enable_reg) begin
            div_cnt_next = tick ? '0 : div_inc;
        end
        if (!chan_en_reg) begin
            pos_next   = '0;
            acc_next   = '0;
            level_next = 1'b0;
        end else if (pulse) begin
            if (range_zero_reg) begin
                pos_next   = '0;
                acc_next   = '0;
                level_next = 1'b0;
            end else begin
                if (mark_space_reg) begin
                    level_next = (pos_reg < duty_eff_reg);
                end else begin
                    level_next = acc_hit;
                    acc_next   = acc_hit ? acc_eff - gap_reg : acc_eff + duty_eff_reg;
                end
                wrap     = pos_last;
                pos_next = pos_last ? '0 : pos_reg + COUNT_WIDTH'(1);
            end
        end
    end

    assign s_take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
            pos_reg     <= '0;
            acc_reg     <= '0;
            level_reg   <= 1'b0;
        end else if (s_take) begin
            div_cnt_reg <= div_cnt_next;
            pos_reg     <= pos_next;
            acc_reg     <= acc_next;
            level_reg   <= level_next;
        end
    end

    assign result.pwm_level   = level_next;
    assign result.period_wrap = wrap;

    pwmms_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    assign m_pwm_level   = m_data.pwm_level;
    assign m_period_wrap = m_data.period_wrap;

    assign disabled_take = s_take && !chan_en_reg && !cfg_write;
    assign state_clear   = !level_reg && (pos_reg == '0) && (acc_reg == '0);
    assign wrap_take     = s_take && wrap;

    `PWMMS_ASSERT_NEXT(a_disabled_clears, aclk, aresetn, disabled_take, state_clear)
    `PWMMS_ASSERT_NEXT(a_wrap_zeroes_pos, aclk, aresetn, wrap_take, pos_reg == '0)
    `PWMMS_ASSERT_NOW(a_stall_means_pending, aclk, aresetn, !s_ready, m_valid)

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PWM output channel. A cycle-accurate predictor
// tracks the divider, position counter and distributed accumulator, and
// every result transaction is compared with the oldest prediction. Directed
// tests cover the corner cases, then random register settings follow, with
// random idle bursts on both channels; a back-to-back run comes last.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    pwmms_pkg::cfg_index_t cfg_index = pwmms_pkg::REG_CLOCK_DIVISOR;
    logic [31:0]           cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic                  s_advance = 1'b0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic                  m_pwm_level;
    logic                  m_period_wrap;

    // predictor copy of the registers
    logic [11:0] sh_divisor     = '0;
    logic        sh_clk_en      = 1'b0;
    logic [31:0] sh_range       = pwmms_pkg::RANGE_RESET;
    logic [31:0] sh_duty        = '0;
    logic        sh_ch_en       = 1'b0;
    logic        sh_mark_space  = 1'b0;

    // predictor copy of the channel state
    logic [11:0] div_cnt   = '0;
    logic [31:0] pos_cnt   = '0;
    logic [31:0] accum     = '0;
    logic        pin_level = 1'b0;

    pwmms_pkg::result_t expected_pins[$];
    pwmms_pkg::result_t want;
    pwmms_pkg::result_t got;
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    int          items_sent   = 0;
    int          gap_pct      = 0;
    int          stall_pct    = 0;

    pwm_channel_mark_space_and_distributed i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_advance     (s_advance),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pwm_level   (m_pwm_level),
        .m_period_wrap (m_period_wrap)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void apply_reg(input pwmms_pkg::cfg_index_t idx,
                                      input logic [31:0] data);
        case (idx)
            pwmms_pkg::REG_CLOCK_DIVISOR:   sh_divisor    = data[11:0];
            pwmms_pkg::REG_CLOCK_ENABLE:    sh_clk_en     = data[0];
            pwmms_pkg::REG_RANGE_COUNT:     sh_range      = data;
            pwmms_pkg::REG_DUTY_COUNT:      sh_duty       = data;
            pwmms_pkg::REG_CHANNEL_ENABLE:  sh_ch_en      = data[0];
            pwmms_pkg::REG_MARK_SPACE_MODE: sh_mark_space = data[0];
            default: ;
        endcase
    endfunction

    // Advance the channel by one source cycle and return the pin state.
    function automatic pwmms_pkg::result_t predict_pin(input logic adv);
        pwmms_pkg::result_t r;
        logic        fire;
        logic [11:0] div_eff;
        logic [31:0] duty;
        logic [32:0] sum;
        logic [32:0] pos_next;
        fire = 1'b0;
        r.period_wrap = 1'b0;
        if (adv && sh_clk_en) begin
            div_eff = (sh_divisor < 12'd2) ? 12'd2 : sh_divisor;
            div_cnt = div_cnt + 12'd1;
            if (div_cnt >= div_eff) begin
                div_cnt = '0;
                fire = 1'b1;
            end
        end
        if (!sh_ch_en) begin
            pin_level = 1'b0;
            pos_cnt = '0;
            accum = '0;
        end else if (fire) begin
            if (sh_range == '0) begin
                pin_level = 1'b0;
                pos_cnt = '0;
                accum = '0;
            end else begin
                duty = (sh_duty > sh_range) ? sh_range : sh_duty;
                if (sh_mark_space) begin
                    pin_level = (pos_cnt < duty);
                end else begin
                    // drop a stale accumulator left above a lowered range
                    if (accum >= sh_range)
                        accum = '0;
                    sum = {1'b0, accum} + {1'b0, duty};
                    if (sum >= {1'b0, sh_range}) begin
                        sum = sum - {1'b0, sh_range};
                        pin_level = 1'b1;
                    end else begin
                        pin_level = 1'b0;
                    end
                    accum = sum[31:0];
                end
                pos_next = {1'b0, pos_cnt} + 33'd1;
                if (pos_next >= {1'b0, sh_range}) begin
                    pos_next = '0;
                    r.period_wrap = 1'b1;
                end
                pos_cnt = pos_next[31:0];
            end
        end
        r.pwm_level = pin_level;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input pwmms_pkg::result_t exp_r,
                                   input pwmms_pkg::result_t act_r);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected level %0b wrap %0b, got level %0b wrap %0b",
                     $time, what, exp_r.pwm_level, exp_r.period_wrap,
                     act_r.pwm_level, act_r.period_wrap);
    endtask

    // Register writes, input transactions and result checks, in edge order.
    always @(posedge aclk) begin
        if (aresetn) begin
            quiet_cycles++;
            if (cfg_valid && cfg_ready) begin
                apply_reg(cfg_index, cfg_wdata);
                quiet_cycles = 0;
            end
            if (s_valid && s_ready) begin
                expected_pins.push_back(predict_pin(s_advance));
                quiet_cycles = 0;
            end
            if (m_valid && m_ready) begin
                got.pwm_level = m_pwm_level;
                got.period_wrap = m_period_wrap;
                if (expected_pins.size() == 0) begin
                    report_mismatch("result with no transaction pending", '0, got);
                end else begin
                    want = expected_pins.pop_front();
                    if (want.pwm_level !== got.pwm_level ||
                        want.period_wrap !== got.period_wrap)
                        report_mismatch("result mismatch", want, got);
                end
                quiet_cycles = 0;
            end
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side back-pressure in short bursts.
    initial begin
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Write one register once every pending result has come back.
    task automatic write_reg(input pwmms_pkg::cfg_index_t idx, input logic [31:0] data);
        s_valid <= 1'b0;
        cfg_valid <= 1'b0;
        // let the last accepted transaction reach the queue first
        @(posedge aclk);
        while (expected_pins.size() != 0)
            @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    task automatic send_advance(input logic adv);
        cfg_valid <= 1'b0;
        if ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_advance <= adv;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_run(input int count);
        repeat (count) send_advance(1'b1);
    endtask

    task automatic test_stopped_clock_and_hold();
        write_reg(pwmms_pkg::REG_CHANNEL_ENABLE, 32'd1);
        write_reg(pwmms_pkg::REG_MARK_SPACE_MODE, 32'd1);
        write_reg(pwmms_pkg::REG_RANGE_COUNT, 32'd4);
        write_reg(pwmms_pkg::REG_DUTY_COUNT, 32'd3);
        send_advance(1'b1);
        send_advance(1'b0);
        send_advance(1'b1);
        // divisor is still 0 from reset, so the divider runs at 2
        write_reg(pwmms_pkg::REG_CLOCK_ENABLE, 32'd1);
        send_advance(1'b1);
        send_advance(1'b0);
        send_run(4);
    endtask

    task automatic test_small_divisor();
        write_reg(pwmms_pkg::REG_CLOCK_DIVISOR, 32'd1);
        send_run(4);
    endtask

    task automatic test_divisor_lowered();
        write_reg(pwmms_pkg::REG_CLOCK_DIVISOR, 32'd9);
        send_run(5);
        write_reg(pwmms_pkg::REG_CLOCK_DIVISOR, 32'd3);
        send_run(2);
    endtask

    task automatic test_range_lowered();
        write_reg(pwmms_pkg::REG_CLOCK_DIVISOR, 32'd0);
        write_reg(pwmms_pkg::REG_MARK_SPACE_MODE, 32'd0);
        write_reg(pwmms_pkg::REG_RANGE_COUNT, 32'd10);
        write_reg(pwmms_pkg::REG_DUTY_COUNT, 32'd9);
        send_run(6);
        // both position and accumulator now sit above the new range
        write_reg(pwmms_pkg::REG_RANGE_COUNT, 32'd2);
        send_run(4);
    endtask

    task automatic test_zero_range_and_clamp();
        write_reg(pwmms_pkg::REG_RANGE_COUNT, 32'd0);
        send_run(2);
        write_reg(pwmms_pkg::REG_RANGE_COUNT, 32'd3);
        write_reg(pwmms_pkg::REG_DUTY_COUNT, 32'hFFFF_FFFF);
        send_run(4);
    endtask

    task automatic test_channel_disabled();
        write_reg(pwmms_pkg::REG_CHANNEL_ENABLE, 32'hFFFF_FFFE);
        send_advance(1'b1);
        send_advance(1'b0);
        send_advance(1'b1);
        write_reg(pwmms_pkg::REG_CHANNEL_ENABLE, 32'h8000_0001);
        send_run(2);
    endtask

    task automatic test_count_extremes();
        write_reg(pwmms_pkg::REG_RANGE_COUNT, 32'hFFFF_FFFF);
        write_reg(pwmms_pkg::REG_DUTY_COUNT, 32'hFFFF_FFFE);
        send_run(4);
        write_reg(pwmms_pkg::REG_MARK_SPACE_MODE, 32'd1);
        send_run(2);
    endtask

    task automatic test_divisor_max();
        gap_pct = 10;
        stall_pct = 10;
        write_reg(pwmms_pkg::REG_CLOCK_DIVISOR, 32'hFFFF_FFFF);
        write_reg(pwmms_pkg::REG_RANGE_COUNT, 32'd3);
        write_reg(pwmms_pkg::REG_DUTY_COUNT, 32'd1);
        send_run(300);
    endtask

    task automatic random_settings();
        logic [31:0] rnd;
        rnd = $urandom;
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
                0:       write_reg(pwmms_pkg::REG_CLOCK_DIVISOR, $urandom);
                1, 2:    write_reg(pwmms_pkg::REG_CLOCK_DIVISOR, $urandom_range(5, 40));
                default: write_reg(pwmms_pkg::REG_CLOCK_DIVISOR, $urandom_range(0, 4));
            endcase
        end
        if ($urandom_range(0, 3) != 0)
            write_reg(pwmms_pkg::REG_CLOCK_ENABLE, {rnd[31:1], $urandom_range(0, 7) != 0});
        if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
                0:       write_reg(pwmms_pkg::REG_RANGE_COUNT, 32'd0);
                1:       write_reg(pwmms_pkg::REG_RANGE_COUNT, $urandom);
                2:       write_reg(pwmms_pkg::REG_RANGE_COUNT,
                                   32'hFFFF_FFFF - $urandom_range(0, 3));
                default: write_reg(pwmms_pkg::REG_RANGE_COUNT, $urandom_range(1, 12));
            endcase
        end
        if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
                0:       write_reg(pwmms_pkg::REG_DUTY_COUNT, $urandom);
                1:       write_reg(pwmms_pkg::REG_DUTY_COUNT, 32'hFFFF_FFFF);
                default: write_reg(pwmms_pkg::REG_DUTY_COUNT, $urandom_range(0, 14));
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            write_reg(pwmms_pkg::REG_CHANNEL_ENABLE, {rnd[30:0], $urandom_range(0, 7) != 0});
        if ($urandom_range(0, 1) == 0)
            write_reg(pwmms_pkg::REG_MARK_SPACE_MODE,
                      {rnd[29:0], 1'b0, $urandom_range(0, 1) == 1});
    endtask

    task automatic test_random_settings();
        while (items_sent < 1650) begin
            random_settings();
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 30;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 10;
                default: stall_pct = 30;
            endcase
            repeat ($urandom_range(20, 120))
                send_advance($urandom_range(0, 3) != 0);
        end
    endtask

    task automatic test_back_to_back();
        gap_pct = 0;
        stall_pct = 0;
        write_reg(pwmms_pkg::REG_CLOCK_DIVISOR, $urandom_range(0, 3));
        write_reg(pwmms_pkg::REG_CLOCK_ENABLE, 32'd1);
        write_reg(pwmms_pkg::REG_RANGE_COUNT, $urandom_range(1, 9));
        write_reg(pwmms_pkg::REG_DUTY_COUNT, $urandom_range(0, 10));
        write_reg(pwmms_pkg::REG_CHANNEL_ENABLE, 32'd1);
        write_reg(pwmms_pkg::REG_MARK_SPACE_MODE, $urandom_range(0, 1));
        repeat (300)
            send_advance($urandom_range(0, 7) != 0);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_stopped_clock_and_hold();
        test_small_divisor();
        test_divisor_lowered();
        test_range_lowered();
        test_zero_range_and_clamp();
        test_channel_disabled();
        test_count_extremes();
        test_divisor_max();
        test_random_settings();
        test_back_to_back();
        // drain outstanding results, then watch for strays
        s_valid <= 1'b0;
        while (expected_pins.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_pins.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/pwmms_pkg.sv
design/pwmms_outbuf.sv
design/pwm_channel_mark_space_and_distributed.sv
tb/sv/tb_top.sv
